@@ src/fltm_pkg.sv @@
// package: shared constants, types and helpers for the page table mapper
`default_nettype none
package fltm_pkg;
   localparam int unsigned POOL_FRAMES_DEF = 64;
   localparam int unsigned ENTRIES_PER_TABLE = 512;
   localparam int unsigned IDX_W = 9;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned VA_W = 48;
   localparam int unsigned PA_W = 52;
   localparam int unsigned BASE_W = 40;
   localparam int unsigned PTE_W = 64;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned LEAF_FRAME_W = 6;
   localparam int unsigned USED_W = 7;

   localparam logic [PTE_W-1:0] PTE_PRESENT = 64'h1;
   localparam logic [PTE_W-1:0] PTE_PW = 64'h3;
   localparam logic [PTE_W-1:0] PTE_HUGE = 64'h80;
   localparam logic [PTE_W-1:0] ADDR_MASK = 64'h0fff_ffff_ffff_f000;

   typedef enum logic [STATUS_W-1:0] {
      ST_MAPPED = 3'd0,
      ST_MISALIGNED = 3'd1,
      ST_NO_FRAMES = 3'd2,
      ST_OCCUPIED = 3'd3,
      ST_BAD_ENTRY = 3'd4
   } status_type;

   // 9-bit table index for a walk level (1..4)
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                    input logic [2:0] lv);
      logic [IDX_W-1:0] r;
      case (lv)
         3'd4: r = va[47:39];
         3'd3: r = va[38:30];
         3'd2: r = va[29:21];
         default: r = va[20:12];
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ src/fltm_if.sv @@
// interfaces: map request, map response and register write channels
`default_nettype none
interface fltm_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [47:0] virt_addr;
   logic [51:0] phys_addr;
   modport source (output valid, mode, virt_addr, phys_addr, input ready);
   modport sink (input valid, mode, virt_addr, phys_addr, output ready);
endinterface

interface fltm_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [5:0] leaf_frame;
   logic [8:0] leaf_index;
   logic [51:0] leaf_entry;
   logic [6:0] frames_used;
   modport source (output valid, status, leaf_frame, leaf_index, leaf_entry,
                   frames_used, input ready);
   modport sink (input valid, status, leaf_frame, leaf_index, leaf_entry,
                 frames_used, output ready);
endinterface

interface fltm_csr_if;
   logic valid;
   logic ready;
   logic [39:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/fltm_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module fltm_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] addr,
   input wire logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // read one word per cycle, and write it as well when wr_en is high
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ src/four_level_page_table_mapper.sv @@
// top level: four-level page table mapper over an on-chip frame pool
//
//   channel  dir  beat
//   req_     in   mode, virt_addr, phys_addr
//   rsp_     out  status, leaf_frame, leaf_index, leaf_entry, frames_used
//   csr_     in   pool_page_base (40 bits)
//
// one request at a time; each level passes through a read state and a check state
// on the table ram, and a new table adds 512 clearing writes plus one link write.
// after reset the root frame is swept to zero, with req_ready held low.
// the response sits in an output register; a stalled rsp_ holds the next walk in S_RESP.
`default_nettype none
module four_level_page_table_mapper #(
   parameter int unsigned POOL_FRAMES = fltm_pkg::POOL_FRAMES_DEF
) (
   input wire logic clock,
   input wire logic reset,
   fltm_req_if.sink req,
   fltm_rsp_if.source rsp,
   fltm_csr_if.sink csr
);
   import fltm_pkg::*;

   localparam int unsigned FRAME_W = (POOL_FRAMES > 2) ? $clog2(POOL_FRAMES) : 1;
   localparam int unsigned ADDR_W = FRAME_W + IDX_W;
   localparam int unsigned DEPTH = POOL_FRAMES * ENTRIES_PER_TABLE;
   localparam int unsigned CNT_W = $clog2(POOL_FRAMES + 1);
   localparam int unsigned PAGE_W = 48;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CHECK, S_ZERO, S_LINK, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0] next_ff, next_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [FRAME_W-1:0] clr_frame_ff, clr_frame_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [2:0] lv_ff, lv_in;
   logic mode_ff, mode_in;
   logic [VA_W-1:0] va_ff, va_in;
   logic [PA_W-1:0] pa_ff, pa_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [LEAF_FRAME_W-1:0] out_frame_ff, out_frame_in;
   logic [IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [PA_W-1:0] out_entry_ff, out_entry_in;
   logic [USED_W-1:0] out_used_ff, out_used_in;

   logic ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PTE_W-1:0] ram_wdata, ram_rdata;

   logic [IDX_W-1:0] cur_idx;
   logic [2:0] leaf_lv;
   logic misaligned;
   logic [PTE_W-1:0] new_link, leaf_word;
   logic [BASE_W:0] link_page;
   logic [PAGE_W-1:0] entry_page, page_off;
   logic page_ok;

   fltm_ram #(.WIDTH(PTE_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata)
   );

   // decode of the current walk
   assign cur_idx = level_index(va_ff, lv_ff);
   assign leaf_lv = mode_ff ? 3'd2 : 3'd1;
   assign misaligned = mode_ff ? (|va_ff[20:0] || |pa_ff[20:0])
                               : (|va_ff[11:0] || |pa_ff[11:0]);
   // frame page keeps its carry above bit 39
   assign link_page = {1'b0, base_ff} + (BASE_W+1)'(clr_frame_ff);
   assign new_link = ({{(PTE_W-BASE_W-1){1'b0}}, link_page} << PAGE_SHIFT) & ADDR_MASK
                     | PTE_PW;
   assign leaf_word = {{(PTE_W-PA_W){1'b0}}, pa_ff} | PTE_PW | (mode_ff ? PTE_HUGE : '0);
   assign entry_page = ram_rdata[59:12];
   assign page_off = entry_page - PAGE_W'(base_ff);
   assign page_ok = (entry_page >= PAGE_W'(base_ff)) && (page_off < PAGE_W'(next_ff));

   // ram port mux
   always_comb begin
      ram_we = 1'b0;
      ram_wdata = '0;
      ram_addr = {frame_ff, cur_idx};
      unique case (state_ff)
         S_CLEAR, S_ZERO: begin
            ram_we = 1'b1;
            ram_addr = {clr_frame_ff, clr_idx_ff};
         end
         S_LINK: begin
            ram_we = 1'b1;
            ram_wdata = new_link;
         end
         S_CHECK: begin
            if (lv_ff == leaf_lv && ram_rdata == '0) begin
               ram_we = 1'b1;
               ram_wdata = leaf_word;
            end
         end
         default: ;
      endcase
   end

   // walk sequencer
   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      next_in = next_ff;
      frame_in = frame_ff;
      clr_frame_in = clr_frame_ff;
      clr_idx_in = clr_idx_ff;
      lv_in = lv_ff;
      mode_in = mode_ff;
      va_in = va_ff;
      pa_in = pa_ff;
      st_in = st_ff;
      out_valid_in = out_valid_ff;
      out_status_in = out_status_ff;
      out_frame_in = out_frame_ff;
      out_idx_in = out_idx_ff;
      out_entry_in = out_entry_ff;
      out_used_in = out_used_ff;
      if (csr.valid) begin
         base_in = csr.data;
      end
      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (&clr_idx_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               va_in = req.virt_addr;
               pa_in = req.phys_addr;
               frame_in = '0;
               lv_in = 3'd4;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (misaligned) begin
               st_in = ST_MISALIGNED;
               state_in = S_RESP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_RESP;
            if (lv_ff == leaf_lv) begin
               if (ram_rdata != '0) begin
                  st_in = ST_OCCUPIED;
               end else begin
                  st_in = ST_MAPPED;
               end
            end else if (!ram_rdata[0]) begin
               if (ram_rdata != '0) begin
                  st_in = ST_BAD_ENTRY;
               end else if (next_ff >= CNT_W'(POOL_FRAMES)) begin
                  st_in = ST_NO_FRAMES;
               end else begin
                  clr_frame_in = next_ff[FRAME_W-1:0];
                  clr_idx_in = '0;
                  next_in = next_ff + 1'b1;
                  state_in = S_ZERO;
               end
            end else if (ram_rdata[7]) begin
               st_in = ST_OCCUPIED;
            end else if (!page_ok) begin
               st_in = ST_BAD_ENTRY;
            end else begin
               frame_in = page_off[FRAME_W-1:0];
               lv_in = lv_ff - 1'b1;
               state_in = S_READ;
            end
         end
         S_ZERO: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (&clr_idx_ff) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            frame_in = clr_frame_ff;
            lv_in = lv_ff - 1'b1;
            state_in = S_READ;
         end
         S_RESP: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_status_in = st_ff;
               out_used_in = USED_W'(next_ff);
               if (st_ff == ST_MAPPED) begin
                  out_frame_in = LEAF_FRAME_W'(frame_ff);
                  out_idx_in = cur_idx;
                  out_entry_in = leaf_word[PA_W-1:0];
               end else begin
                  out_frame_in = '0;
                  out_idx_in = '0;
                  out_entry_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         base_ff <= '0;
         next_ff <= CNT_W'(1);
         clr_frame_ff <= '0;
         clr_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         next_ff <= next_in;
         clr_frame_ff <= clr_frame_in;
         clr_idx_ff <= clr_idx_in;
         out_valid_ff <= out_valid_in;
      end
      frame_ff <= frame_in;
      lv_ff <= lv_in;
      mode_ff <= mode_in;
      va_ff <= va_in;
      pa_ff <= pa_in;
      st_ff <= st_in;
      out_status_ff <= out_status_in;
      out_frame_ff <= out_frame_in;
      out_idx_ff <= out_idx_in;
      out_entry_ff <= out_entry_in;
      out_used_ff <= out_used_in;
   end

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = out_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.leaf_frame = out_frame_ff;
   assign rsp.leaf_index = out_idx_ff;
   assign rsp.leaf_entry = out_entry_ff;
   assign rsp.frames_used = out_used_ff;

   // frame count never drops and never passes the pool size
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= CNT_W'(POOL_FRAMES) && next_ff != '0)
      else $error("frame count out of range");
   a_next_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> next_ff >= $past(next_ff))
      else $error("frame count went down");
   // a clearing pass ends in a link write
   a_zero_link: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ZERO && &clr_idx_ff |=> state_ff == S_LINK)
      else $error("clear pass not followed by link");
endmodule
`default_nettype wire
